>>> rtl/rfe_pkg.sv
// Shared types, constants and the CRC-8 byte update for the request frame encoder.
// Used by rfe_front, rfe_fifo, rfe_back and request_frame_encoder.
package rfe_pkg;

	localparam int FifoDepth = 4;
	localparam int FifoAw    = $clog2(FifoDepth);

	localparam logic CmdStart = 1'b0;
	localparam logic CmdData  = 1'b1;

	localparam logic [7:0] ByteStart  = 8'h02;
	localparam logic [7:0] ByteSync   = 8'hFD;
	localparam logic [7:0] ByteLinked = 8'h01;
	localparam logic [7:0] ByteZero   = 8'h00;
	localparam logic [7:0] ByteReq    = 8'hAF;
	localparam logic [7:0] ByteEnd    = 8'h03;
	localparam logic [7:0] CrcPoly    = 8'h8C;

	localparam logic [16:0] FrameOverhead = 17'd20;
	localparam logic [15:0] LenBias       = 16'd16;

	localparam logic [4:0] StepSof     = 5'd0;
	localparam logic [4:0] StepSync    = 5'd1;
	localparam logic [4:0] StepLenLo   = 5'd2;
	localparam logic [4:0] StepLenHi   = 5'd3;
	localparam logic [4:0] StepCh0     = 5'd4;
	localparam logic [4:0] StepCh1     = 5'd5;
	localparam logic [4:0] StepCh2     = 5'd6;
	localparam logic [4:0] StepCh3     = 5'd7;
	localparam logic [4:0] StepLinked  = 5'd8;
	localparam logic [4:0] StepHdrCrc  = 5'd9;
	localparam logic [4:0] StepZero    = 5'd10;
	localparam logic [4:0] StepReq     = 5'd11;
	localparam logic [4:0] StepMajLo   = 5'd12;
	localparam logic [4:0] StepMajHi   = 5'd13;
	localparam logic [4:0] StepMinLo   = 5'd14;
	localparam logic [4:0] StepMinHi   = 5'd15;
	localparam logic [4:0] StepPlenLo  = 5'd16;
	localparam logic [4:0] StepPlenHi  = 5'd17;
	localparam logic [4:0] StepTrlCrc  = 5'd18;
	localparam logic [4:0] StepTrlEnd  = 5'd19;

	localparam logic RegChannel = 1'b0;
	localparam logic RegMaxLen  = 1'b1;

	typedef enum logic [1:0] {
		KIND_ERR,
		KIND_START,
		KIND_DATA
	} rfe_kind_t;

	typedef struct packed {
		rfe_kind_t   kind;
		logic [15:0] req_major;
		logic [15:0] req_minor;
		logic [15:0] body_len;
		logic [7:0]  data_byte;
		logic        tail;
	} rfe_cmd_t;

	function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
		end
		return c;
	endfunction

endpackage

>>> rtl/rfe_front.sv
// Front end: takes input items, checks length and framing, and queues one command each.
// Depends on rfe_pkg.
module rfe_front import rfe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        accept,
	input  logic        cmd,
	input  logic [15:0] req_major,
	input  logic [15:0] req_minor,
	input  logic [15:0] body_len,
	input  logic [7:0]  data_byte,
	input  logic [15:0] max_frame_len,
	output logic        wr_en,
	output rfe_cmd_t    wr_data
);

	logic        in_frame_q;
	logic [15:0] bytes_left_q;
	logic        in_frame_d;
	logic [15:0] bytes_left_d;
	logic [16:0] total;

	assign total = {1'b0, body_len} + FrameOverhead;
	assign wr_en = accept;

	always_comb begin
		wr_data.req_major = req_major;
		wr_data.req_minor = req_minor;
		wr_data.body_len  = body_len;
		wr_data.data_byte = data_byte;
		wr_data.kind      = KIND_ERR;
		wr_data.tail      = 1'b0;
		in_frame_d        = in_frame_q;
		bytes_left_d      = bytes_left_q;
		if (cmd == CmdStart) begin
			in_frame_d   = 1'b0;
			bytes_left_d = '0;
			if (total <= {1'b0, max_frame_len}) begin
				wr_data.kind = KIND_START;
				wr_data.tail = (body_len == '0);
				in_frame_d   = (body_len != '0);
				bytes_left_d = body_len;
			end
		end else if (!in_frame_q || bytes_left_q == '0) begin
			in_frame_d   = 1'b0;
			bytes_left_d = '0;
		end else begin
			wr_data.kind = KIND_DATA;
			wr_data.tail = (bytes_left_q == 16'd1);
			bytes_left_d = bytes_left_q - 16'd1;
			in_frame_d   = (bytes_left_q != 16'd1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q   <= 1'b0;
			bytes_left_q <= '0;
		end else if (accept) begin
			in_frame_q   <= in_frame_d;
			bytes_left_q <= bytes_left_d;
		end
	end

endmodule

>>> rtl/rfe_fifo.sv
// Short command queue between the front end and the byte sequencer.
// Depends on rfe_pkg.
module rfe_fifo import rfe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr_en,
	input  rfe_cmd_t wr_data,
	input  logic     rd_en,
	output logic     full,
	output logic     valid,
	output rfe_cmd_t rd_data
);

	rfe_cmd_t          mem_q [FifoDepth];
	logic [FifoAw-1:0] wr_ptr_q;
	logic [FifoAw-1:0] rd_ptr_q;
	logic [FifoAw:0]   count_q;

	assign full    = (count_q == (FifoAw+1)'(FifoDepth));
	assign valid   = (count_q != '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + FifoAw'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + FifoAw'(1);
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + (FifoAw+1)'(1);
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - (FifoAw+1)'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !wr_en) else $error("write into full command queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!valid |-> !rd_en) else $error("read from empty command queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (FifoAw+1)'(FifoDepth)) else $error("queue count out of range");
`endif

endmodule

>>> rtl/rfe_back.sv
// Back end: steps through each queued command, emits frame bytes and keeps the CRC.
// Depends on rfe_pkg; fed by rfe_fifo.
module rfe_back import rfe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  rfe_cmd_t    cmd_data,
	input  logic [31:0] channel_id,
	output logic        rd_en,
	input  logic        pop,
	output logic        empty,
	output logic [7:0]  out_byte,
	output logic        last,
	output logic        error
);

	logic [4:0]  step_q;
	logic [7:0]  crc_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;
	logic        last_q;
	logic        error_q;

	logic        advance;
	logic [7:0]  byte_d;
	logic        last_d;
	logic        error_d;
	logic        fold;
	logic        jump_trl;
	logic [15:0] lenf;

	assign lenf    = cmd_data.body_len + LenBias;
	assign advance = cmd_valid && (!out_valid_q || pop);
	assign rd_en   = advance && last_d;

	always_comb begin
		byte_d   = ByteZero;
		error_d  = 1'b0;
		fold     = 1'b0;
		last_d   = 1'b0;
		jump_trl = 1'b0;
		if (cmd_data.kind == KIND_ERR) begin
			error_d = 1'b1;
			last_d  = 1'b1;
		end else if (cmd_data.kind == KIND_DATA && step_q == StepSof) begin
			byte_d   = cmd_data.data_byte;
			fold     = 1'b1;
			last_d   = !cmd_data.tail;
			jump_trl = cmd_data.tail;
		end else begin
			fold = (step_q >= StepSync) && (step_q <= StepPlenHi);
			case (step_q)
				StepSof:    byte_d = ByteStart;
				StepSync:   byte_d = ByteSync;
				StepLenLo:  byte_d = lenf[7:0];
				StepLenHi:  byte_d = lenf[15:8];
				StepCh0:    byte_d = channel_id[7:0];
				StepCh1:    byte_d = channel_id[15:8];
				StepCh2:    byte_d = channel_id[23:16];
				StepCh3:    byte_d = channel_id[31:24];
				StepLinked: byte_d = ByteLinked;
				StepHdrCrc: byte_d = crc_q;
				StepZero:   byte_d = ByteZero;
				StepReq:    byte_d = ByteReq;
				StepMajLo:  byte_d = cmd_data.req_major[7:0];
				StepMajHi:  byte_d = cmd_data.req_major[15:8];
				StepMinLo:  byte_d = cmd_data.req_minor[7:0];
				StepMinHi:  byte_d = cmd_data.req_minor[15:8];
				StepPlenLo: byte_d = cmd_data.body_len[7:0];
				StepPlenHi: begin
					byte_d   = cmd_data.body_len[15:8];
					last_d   = !cmd_data.tail;
					jump_trl = cmd_data.tail;
				end
				StepTrlCrc: byte_d = crc_q;
				StepTrlEnd: begin
					byte_d = ByteEnd;
					last_d = 1'b1;
				end
				default:    last_d = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= StepSof;
			crc_q  <= '0;
		end else if (advance) begin
			if (last_d) begin
				step_q <= StepSof;
			end else if (jump_trl) begin
				step_q <= StepTrlCrc;
			end else begin
				step_q <= step_q + 5'd1;
			end
			if (cmd_data.kind == KIND_START && step_q == StepSof) begin
				crc_q <= '0;
			end else if (fold) begin
				crc_q <= crc_update(crc_q, byte_d);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_byte_q <= byte_d;
			last_q     <= last_d;
			error_q    <= error_d;
		end
	end

	assign empty    = !out_valid_q;
	assign out_byte = out_byte_q;
	assign last     = last_q;
	assign error    = error_q;

`ifndef SYNTHESIS
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= StepTrlEnd) else $error("sequencer step out of range");
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_data.kind == KIND_ERR) |-> step_q == StepSof)
		else $error("error command entered mid-sequence");
	a_trl_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && step_q == StepTrlCrc) |=> step_q == StepTrlEnd)
		else $error("trailer CRC not followed by end marker");
`endif

endmodule

>>> rtl/request_frame_encoder.sv
// Request frame encoder, top level: configuration registers, front end, queue, back end.
// Depends on rfe_pkg, rfe_front, rfe_fifo and rfe_back.
//
// Input channel: push/full. A start item (cmd 0) yields the 18 header bytes, plus the
// trailer CRC and end marker when body_len is 0; each data item (cmd 1) yields its
// payload byte, plus CRC and end marker after the last one. An oversize start or a
// stray data byte yields one result with error set and out_byte 0.
// Result channel: empty/pop; last marks the final result of each input item.
// The first byte of an item passes through the command queue and then the output register before it is visible.
// Throughput: one output byte per cycle from the back end sequencer while pop keeps up; data
// items pass at one per cycle, a start item holds the sequencer for all of its header bytes
// (and its trailer) while the four-entry command queue keeps taking items.
// When pop stays low the output register holds, the sequencer stalls, the queue
// fills and full rises; nothing is dropped.
// Reset clears the queue, the frame state and the output valid flag; channel_id resets
// to 0 and max_frame_len to 65535. Registers sit at byte addresses 0 and 4 of the
// APB port and should be written only while the block is idle.
module request_frame_encoder import rfe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        cmd,
	input  logic [15:0] req_major,
	input  logic [15:0] req_minor,
	input  logic [15:0] body_len,
	input  logic [7:0]  data_byte,
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_byte,
	output logic        last,
	output logic        error,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [31:0] channel_id_q;
	logic [15:0] max_frame_len_q;
	logic        cfg_wr;
	logic        accept;
	logic        wr_en;
	logic        rd_en;
	logic        cmd_valid;
	rfe_cmd_t    wr_data;
	rfe_cmd_t    rd_data;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == RegMaxLen) ? {16'd0, max_frame_len_q} : channel_id_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_id_q    <= '0;
			max_frame_len_q <= 16'hFFFF;
		end else if (cfg_wr) begin
			if (paddr[2] == RegChannel) begin
				channel_id_q <= pwdata;
			end else begin
				max_frame_len_q <= pwdata[15:0];
			end
		end
	end

	assign accept = push && !full;

	rfe_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.cmd           (cmd),
		.req_major     (req_major),
		.req_minor     (req_minor),
		.body_len      (body_len),
		.data_byte     (data_byte),
		.max_frame_len (max_frame_len_q),
		.wr_en         (wr_en),
		.wr_data       (wr_data)
	);

	rfe_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.full    (full),
		.valid   (cmd_valid),
		.rd_data (rd_data)
	);

	rfe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_data   (rd_data),
		.channel_id (channel_id_q),
		.rd_en      (rd_en),
		.pop        (pop),
		.empty      (empty),
		.out_byte   (out_byte),
		.last       (last),
		.error      (error)
	);

endmodule

>>> dv/request_frame_encoder_tb.sv
// Testbench for request_frame_encoder: a directed table of requests, then random frames
// under several register settings and handshake idling mixes, scored byte by byte.
// Depends on rfe_pkg and the request_frame_encoder RTL.
module request_frame_encoder_tb import rfe_pkg::*; ;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0] SOF_BYTE    = 8'h02;
	localparam logic [7:0] SYNC_BYTE   = 8'hFD;
	localparam logic [7:0] LINKED_BYTE = 8'h01;
	localparam logic [7:0] PAD_BYTE    = 8'h00;
	localparam logic [7:0] REQ_BYTE    = 8'hAF;
	localparam logic [7:0] END_BYTE    = 8'h03;
	localparam logic [16:0] FRAME_FIXED_LEN = 17'd20;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int ITEMS_PER_SET = 8;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last;
		logic       error;
	} frame_out_t;

	typedef struct packed {
		logic        cmd;
		logic [15:0] major;
		logic [15:0] minor;
		logic [15:0] plen;
		logic [7:0]  data;
		logic        typed_err;
	} req_row_t;

	localparam frame_out_t ERR_RESULT = '{8'h00, 1'b1, 1'b1};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic        cmd = CmdStart;
	logic [15:0] req_major = '0;
	logic [15:0] req_minor = '0;
	logic [15:0] body_len = '0;
	logic [7:0]  data_byte = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [7:0]  out_byte;
	logic        last;
	logic        error;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	logic [31:0] chan_id_m = 32'd0;
	logic [15:0] max_len_m = 16'hFFFF;
	logic [7:0]  frame_crc = 8'd0;
	logic [15:0] payload_left = 16'd0;
	logic        frame_open = 1'b0;

	frame_out_t item_bytes[$];
	frame_out_t bytes_due[$];
	frame_out_t due_r;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int cycle_count = 0;
	int mismatch_count = 0;
	int items_sent = 0;
	int results_seen = 0;
	int frames_closed = 0;
	int error_results = 0;

	req_row_t dir_rows [20] = '{
		'{CmdData,  16'h0000, 16'h0000, 16'd0,     8'h5A, 1'b1},
		'{CmdStart, 16'h0000, 16'h0000, 16'd0,     8'h00, 1'b0},
		'{CmdStart, 16'hFFFF, 16'hFFFF, 16'd0,     8'hFF, 1'b0},
		'{CmdStart, 16'h0001, 16'h8000, 16'd65515, 8'h00, 1'b0},
		'{CmdStart, 16'h1234, 16'hABCD, 16'd3,     8'h00, 1'b0},
		'{CmdData,  16'h0000, 16'h0000, 16'd0,     8'h00, 1'b0},
		'{CmdData,  16'h0000, 16'h0000, 16'd0,     8'hFF, 1'b0},
		'{CmdData,  16'h0000, 16'h0000, 16'd0,     8'hA5, 1'b0},
		'{CmdData,  16'hFFFF, 16'hFFFF, 16'hFFFF,  8'h3C, 1'b1},
		'{CmdStart, 16'h5555, 16'hAAAA, 16'd2,     8'h00, 1'b0},
		'{CmdData,  16'h0000, 16'h0000, 16'd0,     8'h5A, 1'b0},
		'{CmdStart, 16'hAAAA, 16'h5555, 16'd1,     8'h00, 1'b0},
		'{CmdData,  16'h0000, 16'h0000, 16'd0,     8'h7E, 1'b0},
		'{CmdStart, 16'h0000, 16'h0000, 16'hFFFF,  8'h00, 1'b1},
		'{CmdStart, 16'h0000, 16'h0000, 16'd65516, 8'h00, 1'b1},
		'{CmdStart, 16'h00FF, 16'hFF00, 16'd1,     8'h00, 1'b0},
		'{CmdStart, 16'h0000, 16'h0000, 16'hFFFF,  8'h00, 1'b1},
		'{CmdData,  16'h0000, 16'h0000, 16'd0,     8'h81, 1'b1},
		'{CmdStart, 16'h8001, 16'h0180, 16'd0,     8'h00, 1'b0},
		'{CmdData,  16'h0000, 16'h0000, 16'd0,     8'h00, 1'b1}
	};

	request_frame_encoder i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.cmd       (cmd),
		.req_major (req_major),
		.req_minor (req_minor),
		.body_len  (body_len),
		.data_byte (data_byte),
		.empty     (empty),
		.pop       (pop),
		.out_byte  (out_byte),
		.last      (last),
		.error     (error),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		repeat (8) c = {1'b0, c[7:1]} ^ (c[0] ? 8'h8C : 8'h00);
		return c;
	endfunction

	function automatic void emit(input logic [7:0] b, input logic fold);
		if (fold)
			frame_crc = crc_fold(frame_crc, b);
		item_bytes.push_back('{b, 1'b0, 1'b0});
	endfunction

	function automatic void emit_trailer();
		emit(frame_crc, 1'b0);
		emit(END_BYTE, 1'b0);
		frame_open = 1'b0;
		payload_left = 16'd0;
		frames_closed++;
	endfunction

	function automatic void encode_item(input logic c, input logic [15:0] maj,
			input logic [15:0] mnr, input logic [15:0] plen, input logic [7:0] d);
		logic [16:0] total;
		logic [15:0] len_word;
		item_bytes.delete();
		total = FRAME_FIXED_LEN + {1'b0, plen};
		len_word = total[15:0] - 16'd4;
		if (c == CmdStart) begin
			frame_open = 1'b0;
			payload_left = 16'd0;
			if (total > {1'b0, max_len_m}) begin
				item_bytes.push_back(ERR_RESULT);
				error_results++;
			end else begin
				frame_crc = 8'd0;
				emit(SOF_BYTE, 1'b0);
				emit(SYNC_BYTE, 1'b1);
				emit(len_word[7:0], 1'b1);
				emit(len_word[15:8], 1'b1);
				emit(chan_id_m[7:0], 1'b1);
				emit(chan_id_m[15:8], 1'b1);
				emit(chan_id_m[23:16], 1'b1);
				emit(chan_id_m[31:24], 1'b1);
				emit(LINKED_BYTE, 1'b1);
				emit(frame_crc, 1'b1);
				emit(PAD_BYTE, 1'b1);
				emit(REQ_BYTE, 1'b1);
				emit(maj[7:0], 1'b1);
				emit(maj[15:8], 1'b1);
				emit(mnr[7:0], 1'b1);
				emit(mnr[15:8], 1'b1);
				emit(plen[7:0], 1'b1);
				emit(plen[15:8], 1'b1);
				if (plen == 16'd0) begin
					emit_trailer();
				end else begin
					frame_open = 1'b1;
					payload_left = plen;
				end
			end
		end else if (!frame_open || payload_left == 16'd0) begin
			frame_open = 1'b0;
			payload_left = 16'd0;
			item_bytes.push_back(ERR_RESULT);
			error_results++;
		end else begin
			emit(d, 1'b1);
			payload_left = payload_left - 16'd1;
			if (payload_left == 16'd0)
				emit_trailer();
		end
		item_bytes[item_bytes.size() - 1].last = 1'b1;
	endfunction

	task automatic send_item(input logic c, input logic [15:0] maj, input logic [15:0] mnr,
			input logic [15:0] plen, input logic [7:0] d, input logic typed_err);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		cmd <= c;
		req_major <= maj;
		req_minor <= mnr;
		body_len <= plen;
		data_byte <= d;
		do @(posedge clk); while (full);
		encode_item(c, maj, mnr, plen, d);
		if (typed_err)
			bytes_due.push_back(ERR_RESULT);
		else
			foreach (item_bytes[i]) bytes_due.push_back(item_bytes[i]);
		items_sent++;
	endtask

	// hold input until every due byte has left the block
	task automatic settle();
		push <= 1'b0;
		while (bytes_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (idx == RegChannel)
			chan_id_m = val;
		else
			max_len_m = val[15:0];
	endtask

	task automatic send_frame();
		int plen;
		int n;
		int roll;
		if ($urandom_range(99) < 8)
			send_item(CmdData, 16'($urandom), 16'($urandom), 16'($urandom),
				8'($urandom), 1'b0);
		roll = $urandom_range(99);
		if (roll < 75)
			plen = $urandom_range(0, 8);
		else if (roll < 90)
			plen = $urandom_range(9, 40);
		else
			plen = $urandom_range(0, 65535);
		n = (plen <= 40) ? plen : $urandom_range(0, 3);
		if ($urandom_range(99) < 12)
			n = $urandom_range(0, n);
		send_item(CmdStart, 16'($urandom), 16'($urandom), 16'(plen), 8'($urandom), 1'b0);
		repeat (n)
			send_item(CmdData, 16'($urandom), 16'($urandom), 16'($urandom),
				8'($urandom), 1'b0);
	endtask

	always @(posedge clk) begin
		pop <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (bytes_due.size() == 0) begin
				$error("unexpected transfer: out_byte %h last %b error %b",
					out_byte, last, error);
				mismatch_count++;
			end else begin
				due_r = bytes_due.pop_front();
				results_seen++;
				if (out_byte !== due_r.out_byte) begin
					$error("out_byte: expected %h, got %h", due_r.out_byte, out_byte);
					mismatch_count++;
				end
				if (last !== due_r.last) begin
					$error("last: expected %b, got %b", due_r.last, last);
					mismatch_count++;
				end
				if (error !== due_r.error) begin
					$error("error: expected %b, got %b", due_r.error, error);
					mismatch_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		logic [31:0] set_chan [6];
		logic [31:0] set_max [6];
		int base;
		int frame_no;
		set_chan = '{32'hFFFF_FFFF, $urandom, $urandom, $urandom, $urandom, 32'd0};
		set_max = '{32'd20, $urandom_range(24, 64), 32'd0, 32'd65535, 32'd19, 32'd65535};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 14;
		recv_idle_pct = 69;
		foreach (dir_rows[i])
			send_item(dir_rows[i].cmd, dir_rows[i].major, dir_rows[i].minor,
				dir_rows[i].plen, dir_rows[i].data, dir_rows[i].typed_err);
		for (int mode = 0; mode < 3; mode++) begin
			send_idle_pct = (mode == 0) ? 14 : (mode == 1) ? 69 : 0;
			recv_idle_pct = (mode == 0) ? 69 : (mode == 1) ? 14 : 0;
			for (int s = 0; s < 2; s++) begin
				settle();
				write_reg(RegChannel, set_chan[2 * mode + s]);
				write_reg(RegMaxLen, set_max[2 * mode + s]);
				base = items_sent;
				frame_no = 0;
				while (items_sent - base < ITEMS_PER_SET) begin
					send_frame();
					frame_no++;
					if (mode == 1 && s == 1 && frame_no == 2)
						settle();
				end
			end
		end
		settle();
		$display("tb: %0d items sent, %0d bytes checked, %0d frames closed, %0d error results",
			items_sent, results_seen, frames_closed, error_results);
		$display("tb: 7 register settings, max_frame_len from 0 to 65535, three idling mixes");
		if (mismatch_count == 0 && bytes_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
